FILE: design/gf128_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and controller/datapath interface types for the GF(2^128) unit.
package gf128_pkg;

  localparam int ELEM_W = 128;
  localparam int HALF_W = 64;
  localparam int DIGIT_W_DEFAULT = 8;

  // x^128 = x^7 + x^2 + x + 1
  localparam logic [ELEM_W-1:0] FOLD_POLY = 128'h87;
  localparam logic [ELEM_W-1:0] ELEM_ONE  = 128'h1;

  localparam logic CMD_MUL = 1'b0;
  localparam logic CMD_POW = 1'b1;

  typedef enum logic [1:0] {
    SRC_BASE_EXPO = 2'd0,
    SRC_ACC_BASE  = 2'd1,
    SRC_BASE_BASE = 2'd2
  } mul_src_t;

  typedef struct packed {
    logic     load;
    logic     mul_init;
    mul_src_t mul_src;
    logic     mul_step;
    logic     wr_acc;
    logic     wr_base;
    logic     expo_shift;
  } dp_cmd_t;

  typedef struct packed {
    logic mul_last;
    logic is_pow;
    logic expo_bit;
    logic expo_zero;
    logic expo_rest_zero;
  } dp_stat_t;

endpackage

FILE: design/gf128_datapath.sv
`timescale 1ns / 1ps
// Datapath: operand registers and a digit-serial carryless multiplier with reduction.
module gf128_datapath #(
  parameter int DIGIT_W = gf128_pkg::DIGIT_W_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  gf128_pkg::dp_cmd_t              cmd,
  output gf128_pkg::dp_stat_t             stat,
  input  logic                            command,
  input  logic [gf128_pkg::HALF_W-1:0]    operand_a_high,
  input  logic [gf128_pkg::HALF_W-1:0]    operand_a_low,
  input  logic [gf128_pkg::HALF_W-1:0]    operand_b_high,
  input  logic [gf128_pkg::HALF_W-1:0]    operand_b_low,
  output logic [gf128_pkg::HALF_W-1:0]    result_high,
  output logic [gf128_pkg::HALF_W-1:0]    result_low
);

  localparam int EW    = gf128_pkg::ELEM_W;
  localparam int STEPS = EW / DIGIT_W;
  localparam int CNT_W = $clog2(STEPS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STEPS - 1);

  logic [EW-1:0]    base;
  logic [EW-1:0]    expo;
  logic [EW-1:0]    acc;
  logic [EW-1:0]    mx;
  logic [EW-1:0]    my;
  logic [EW-1:0]    prod;
  logic [CNT_W-1:0] cnt;
  logic             is_pow;

  logic [DIGIT_W-1:0]    digit;
  logic [EW+DIGIT_W-1:0] wide;
  logic [DIGIT_W-1:0]    spill;
  logic [EW-1:0]         prod_next;

  // Horner step, top digit first: prod * x^D + mx * digit, then fold the spill back in
  always_comb begin
    digit = my[EW-1 -: DIGIT_W];
    wide  = {prod, DIGIT_W'(0)};
    for (int j = 0; j < DIGIT_W; j++) begin
      if (digit[j]) begin
        wide = wide ^ ({DIGIT_W'(0), mx} << j);
      end
    end
    spill     = wide[EW+DIGIT_W-1:EW];
    prod_next = wide[EW-1:0];
    for (int j = 0; j < DIGIT_W; j++) begin
      if (spill[j]) begin
        prod_next = prod_next ^ (gf128_pkg::FOLD_POLY << j);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      is_pow <= 1'b0;
    end else begin
      if (cmd.load) begin
        base   <= {operand_a_high, operand_a_low};
        expo   <= {operand_b_high, operand_b_low};
        acc    <= gf128_pkg::ELEM_ONE;
        is_pow <= (command == gf128_pkg::CMD_POW);
      end
      if (cmd.mul_init) begin
        prod <= '0;
        cnt  <= '0;
        unique case (cmd.mul_src)
          gf128_pkg::SRC_BASE_EXPO: begin
            mx <= base;
            my <= expo;
          end
          gf128_pkg::SRC_ACC_BASE: begin
            mx <= cmd.wr_acc ? prod_next : acc;
            my <= base;
          end
          default: begin
            mx <= base;
            my <= base;
          end
        endcase
      end else if (cmd.mul_step) begin
        prod <= prod_next;
        my   <= my << DIGIT_W;
        cnt  <= cnt + CNT_W'(1);
      end
      if (cmd.wr_acc) begin
        acc <= prod_next;
      end
      if (cmd.wr_base) begin
        base <= prod_next;
      end
      if (cmd.expo_shift) begin
        expo <= expo >> 1;
      end
    end
  end

  assign stat.mul_last       = (cnt == CNT_LAST);
  assign stat.is_pow         = is_pow;
  assign stat.expo_bit       = expo[0];
  assign stat.expo_zero      = (expo == '0);
  assign stat.expo_rest_zero = (expo[EW-1:1] == '0);

  assign result_high = acc[EW-1:gf128_pkg::HALF_W];
  assign result_low  = acc[gf128_pkg::HALF_W-1:0];

endmodule

FILE: design/gf128_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences multiply and square-and-multiply over the shared multiplier.
module gf128_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  output logic                done,
  output gf128_pkg::dp_cmd_t  cmd,
  input  gf128_pkg::dp_stat_t stat
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_MUL,
    S_CHECK,
    S_ACCMUL,
    S_SQR,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    cmd.mul_src = gf128_pkg::SRC_BASE_EXPO;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_SETUP;
        end
      end
      S_SETUP: begin
        if (stat.is_pow) begin
          state_next = S_CHECK;
        end else begin
          cmd.mul_init = 1'b1;
          cmd.mul_src  = gf128_pkg::SRC_BASE_EXPO;
          state_next   = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        if (stat.mul_last) begin
          cmd.wr_acc = 1'b1;
          state_next = S_DONE;
        end
      end
      S_CHECK: begin
        priority if (stat.expo_zero) begin
          state_next = S_DONE;
        end else if (stat.expo_bit) begin
          cmd.mul_init = 1'b1;
          cmd.mul_src  = gf128_pkg::SRC_ACC_BASE;
          state_next   = S_ACCMUL;
        end else begin
          cmd.mul_init = 1'b1;
          cmd.mul_src  = gf128_pkg::SRC_BASE_BASE;
          state_next   = S_SQR;
        end
      end
      S_ACCMUL: begin
        cmd.mul_step = 1'b1;
        if (stat.mul_last) begin
          cmd.wr_acc = 1'b1;
          if (stat.expo_rest_zero) begin
            state_next = S_DONE;
          end else begin
            // squaring only reads base, so it can start as the product lands
            cmd.mul_init = 1'b1;
            cmd.mul_src  = gf128_pkg::SRC_BASE_BASE;
            state_next   = S_SQR;
          end
        end
      end
      S_SQR: begin
        cmd.mul_step = 1'b1;
        if (stat.mul_last) begin
          cmd.wr_base    = 1'b1;
          cmd.expo_shift = 1'b1;
          state_next     = S_CHECK;
        end
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state_next == S_DONE);
    end
  end

  assign busy = (state != S_IDLE);

endmodule

FILE: design/gf2_128_multiply_power_unit.sv
`timescale 1ns / 1ps
// Top level of the GF(2^128) multiply / power unit.
//
// A request is taken when start is high and busy is low; busy then stays high
// until the result has been shown. The result is valid on result_high/result_low in
// the single cycle in which done is high and must be captured then: the unit
// cannot be stalled. Everything runs through one digit-serial multiplier that
// handles DIGIT_W bits of the second operand per cycle. A power request scans
// the exponent from bit 0 and takes one check per bit up to the highest set bit,
// one squaring of the base per bit below it and one product into the accumulator
// per set bit.
module gf2_128_multiply_power_unit #(
  parameter int DIGIT_W = gf128_pkg::DIGIT_W_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         command,
  input  logic [gf128_pkg::HALF_W-1:0] operand_a_high,
  input  logic [gf128_pkg::HALF_W-1:0] operand_a_low,
  input  logic [gf128_pkg::HALF_W-1:0] operand_b_high,
  input  logic [gf128_pkg::HALF_W-1:0] operand_b_low,
  output logic                         done,
  output logic [gf128_pkg::HALF_W-1:0] result_high,
  output logic [gf128_pkg::HALF_W-1:0] result_low
);

  gf128_pkg::dp_cmd_t  cmd;
  gf128_pkg::dp_stat_t stat;

  gf128_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd),
    .stat  (stat)
  );

  gf128_datapath #(
    .DIGIT_W (DIGIT_W)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .command        (command),
    .operand_a_high (operand_a_high),
    .operand_a_low  (operand_a_low),
    .operand_b_high (operand_b_high),
    .operand_b_low  (operand_b_low),
    .result_high    (result_high),
    .result_low     (result_low)
  );

endmodule
